// ===== src/signed_binary_to_decimal_ascii_macros.svh =====
// ----------------------------------------------------------------------------
// Signed binary to decimal ASCII - assertion macros
// Shared concurrent assertion forms for the converter's checks.
// ----------------------------------------------------------------------------
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBDA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBDA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/sbda_pkg.sv =====
// ----------------------------------------------------------------------------
// Signed binary to decimal ASCII - package
// Sequencer states, control bundle and character constants.
// ----------------------------------------------------------------------------
`default_nettype none

package sbda_pkg;

   localparam int unsigned BCD_WIDTH = 4;

   localparam logic [6:0] CHAR_ZERO  = 7'd48;
   localparam logic [6:0] CHAR_NINE  = 7'd57;
   localparam logic [6:0] CHAR_MINUS = 7'd45;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   // Commands from the sequencer to the shift-and-add-3 datapath.
   typedef struct packed {
      logic load;
      logic dabble;
      logic digit_shift;
   } dab_ctrl_type;

endpackage

`default_nettype wire

// ===== src/sbda_dabble.sv =====
// ----------------------------------------------------------------------------
// Signed binary to decimal ASCII - double dabble datapath
// Bit-serial binary to BCD shifter with a digit-wide output shift.
// ----------------------------------------------------------------------------
`default_nettype none

module sbda_dabble import sbda_pkg::*; #(
   parameter int VALUE_WIDTH = 64,
   parameter int NUM_DIGITS  = 20
) (
   input  wire logic                   clock,
   input  wire dab_ctrl_type           ctrl,
   input  wire logic [VALUE_WIDTH-1:0] magnitude,
   output logic      [BCD_WIDTH-1:0]   top_digit
);

   localparam int BCD_BITS = NUM_DIGITS * BCD_WIDTH;

   logic [VALUE_WIDTH-1:0] mag_ff;
   logic [BCD_BITS-1:0]    bcd_ff;
   logic [BCD_BITS-1:0]    adjusted;

   // Each digit of five or more gets three added before the shift doubles it.
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i*BCD_WIDTH +: BCD_WIDTH] >= 4'd5) begin
            adjusted[i*BCD_WIDTH +: BCD_WIDTH] = bcd_ff[i*BCD_WIDTH +: BCD_WIDTH] + 4'd3;
         end else begin
            adjusted[i*BCD_WIDTH +: BCD_WIDTH] = bcd_ff[i*BCD_WIDTH +: BCD_WIDTH];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         mag_ff <= magnitude;
         bcd_ff <= '0;
      end else if (ctrl.dabble) begin
         mag_ff <= {mag_ff[VALUE_WIDTH-2:0], 1'b0};
         bcd_ff <= {adjusted[BCD_BITS-2:0], mag_ff[VALUE_WIDTH-1]};
      end else if (ctrl.digit_shift) begin
         bcd_ff <= {bcd_ff[BCD_BITS-BCD_WIDTH-1:0], {BCD_WIDTH{1'b0}}};
      end
   end

   assign top_digit = bcd_ff[BCD_BITS-1 -: BCD_WIDTH];

endmodule

`default_nettype wire

// ===== src/signed_binary_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// Signed binary to decimal ASCII converter
// Prints a two's complement integer as a run of decimal ASCII characters.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_value and raise start while busy is low; the value is taken at
//   that clock edge and only its low VALUE_WIDTH bits are used. busy stays
//   high until the last character has been issued.
//   Characters leave most significant first on rsp_character, each valid for
//   exactly one cycle with rsp_valid high; a negative value opens with '-'.
//   rsp_last marks the final character of the run. Zero prints as one '0'.
//   The receiver cannot stall: every strobed character is a transfer.
// Timing:
//   The magnitude is shifted into a BCD register one bit per cycle. Leading
//   zero digits are then dropped one digit per cycle, and one character is
//   issued per cycle. A new value is not accepted until busy is low again,
//   so a run is finished before the next value can be started.
// Reset:
//   Synchronous reset returns the sequencer to idle and clears the strobe;
//   a run in progress is abandoned.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_binary_to_decimal_ascii import sbda_pkg::*; #(
   parameter int VALUE_WIDTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [63:0] req_value,
   output logic             rsp_valid,
   output logic [6:0]       rsp_character,
   output logic             rsp_last
);

   // Enough digits for 2^VALUE_WIDTH; log10(2) taken as 0.30103.
   localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);
   localparam int DIG_W      = $clog2(NUM_DIGITS + 1);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [DIG_W-1:0] remain_ff, remain_in;
   logic             neg_ff, neg_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [6:0]       rsp_character_ff, rsp_character_in;
   logic             rsp_last_ff, rsp_last_in;

   dab_ctrl_type           ctrl;
   logic [VALUE_WIDTH-1:0] raw;
   logic [VALUE_WIDTH-1:0] magnitude;
   logic [BCD_WIDTH-1:0]   top_digit;
   logic                   accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // The most negative value negates to itself, which read unsigned is the
   // correct magnitude.
   assign raw       = req_value[VALUE_WIDTH-1:0];
   assign magnitude = raw[VALUE_WIDTH-1] ? VALUE_WIDTH'(~raw + VALUE_WIDTH'(1)) : raw;

   sbda_dabble #(
      .VALUE_WIDTH(VALUE_WIDTH),
      .NUM_DIGITS (NUM_DIGITS)
   ) u_dabble (
      .clock    (clock),
      .ctrl     (ctrl),
      .magnitude(magnitude),
      .top_digit(top_digit)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (count_ff == CNT_W'(1)) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // Stop dropping digits at the first nonzero one, or keep the last
            // digit so that zero still prints.
            if (!(top_digit == '0 && remain_ff > DIG_W'(1))) begin
               state_in = neg_ff ? ST_SIGN : ST_DIGITS;
            end
         end
         ST_SIGN: begin
            state_in = ST_DIGITS;
         end
         ST_DIGITS: begin
            if (remain_ff == DIG_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath commands, counters and the next character.
   always_comb begin
      ctrl             = '0;
      count_in         = count_ff;
      remain_in        = remain_ff;
      neg_in           = neg_ff;
      rsp_valid_in     = 1'b0;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctrl.load = 1'b1;
               count_in  = CNT_W'(VALUE_WIDTH);
               neg_in    = raw[VALUE_WIDTH-1];
            end
         end
         ST_CONVERT: begin
            ctrl.dabble = 1'b1;
            count_in    = count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1)) begin
               remain_in = DIG_W'(NUM_DIGITS);
            end
         end
         ST_SKIP: begin
            if (top_digit == '0 && remain_ff > DIG_W'(1)) begin
               ctrl.digit_shift = 1'b1;
               remain_in        = remain_ff - DIG_W'(1);
            end
         end
         ST_SIGN: begin
            rsp_valid_in     = 1'b1;
            rsp_character_in = CHAR_MINUS;
         end
         ST_DIGITS: begin
            ctrl.digit_shift = 1'b1;
            remain_in        = remain_ff - DIG_W'(1);
            rsp_valid_in     = 1'b1;
            rsp_character_in = CHAR_ZERO + 7'(top_digit);
            rsp_last_in      = (remain_ff == DIG_W'(1));
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         remain_ff    <= '0;
         neg_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         neg_ff       <= neg_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

`include "signed_binary_to_decimal_ascii_macros.svh"

   `SBDA_ASSERT_SAME(a_char_legal, clock, reset, rsp_valid, (rsp_character == CHAR_MINUS) || ((rsp_character >= CHAR_ZERO) && (rsp_character <= CHAR_NINE)), "character outside minus and digits")
   `SBDA_ASSERT_SAME(a_minus_not_last, clock, reset, rsp_valid && (rsp_character == CHAR_MINUS), !rsp_last, "minus sign ends a run")
   `SBDA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy && !rsp_valid, "accepted transfer did not start a conversion")
   `SBDA_ASSERT_SAME(a_digits_left, clock, reset, state_ff == ST_DIGITS, remain_ff != '0, "digit count ran out during emission")

endmodule

`default_nettype wire
